FILE: hw/rtl/kos_pkg.sv
`default_nettype none

package kos_pkg;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 5;

  localparam logic [CFG_IDX_W-1:0] CFG_RANK_K         = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SELECT_LARGEST = 2'd1;

  localparam int RANK_W = 5;

  // per-cycle command broadcast to every cell of the chain
  typedef struct packed {
    logic load;        // a word is taken in this cycle
    logic shift_down;  // drop the lowest entry instead of the highest
  } kos_cell_ctl_t;

endpackage

`default_nettype wire

FILE: hw/rtl/kos_if.sv
`default_nettype none

interface kos_in_if #(
  parameter int VALUE_WIDTH = 32
);
  logic                          valid;
  logic                          ready;
  logic signed [VALUE_WIDTH-1:0] value;
  logic                          last;

  modport source (output valid, output value, output last, input ready);
  modport sink   (input valid, input value, input last, output ready);
endinterface

interface kos_out_if #(
  parameter int VALUE_WIDTH = 32
);
  logic                          valid;
  logic                          ready;
  logic signed [VALUE_WIDTH-1:0] kth_value;
  logic                          too_few;

  modport source (output valid, output kth_value, output too_few, input ready);
  modport sink   (input valid, input kth_value, input too_few, output ready);
endinterface

interface kos_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [kos_pkg::CFG_IDX_W-1:0]  index;
  logic [kos_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/kos_cell.sv
`default_nettype none

// One slot of the sorted (ascending) chain of kept values.
module kos_cell #(
  parameter int VALUE_WIDTH = 32
) (
  input  wire                            clk,
  input  wire kos_pkg::kos_cell_ctl_t    ctl,
  input  wire                            live,       // slot holds a kept value
  input  wire signed [VALUE_WIDTH-1:0]   value_in,
  input  wire                            below_ins,
  input  wire signed [VALUE_WIDTH-1:0]   below_val,
  input  wire                            above_gt,
  input  wire signed [VALUE_WIDTH-1:0]   above_val,
  output logic signed [VALUE_WIDTH-1:0]  cur_val,
  output logic                           ins,
  output logic                           gt
);
  import kos_pkg::*;

  logic signed [VALUE_WIDTH-1:0] cur_r;

  // ins: new word goes at or below this slot; gt: new word beats this slot
  assign ins     = !live || (value_in < cur_r);
  assign gt      = live && (value_in > cur_r);
  assign cur_val = cur_r;

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      if (ctl.shift_down) begin
        if (gt) begin
          cur_r <= above_gt ? above_val : value_in;
        end
      end else if (ins) begin
        cur_r <= below_ins ? below_val : value_in;
      end
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/kth_order_statistic_select.sv
// Channel  Dir  Payload                     Word
// in_ch    in   value[VW], last             one element of a data set
// out_ch   out  kth_value[VW], too_few      selected value of a finished set
// cfg_ch   in   index[2], data[5]           register write (rank_k, select_largest)
//
// One element is taken per cycle when input is not stalled; every cell of the chain
// updates in parallel. After the word marked last, input stalls while the result is
// moved from the chain into the output register, and stays stalled while that register
// still holds an untaken result.
// Reset (synchronous, rst_n low) sets rank_k = 1, smallest mode, empty chain.
// The cfg channel is always ready.
`default_nettype none

module kth_order_statistic_select #(
  parameter int K_MAX       = 16,
  parameter int VALUE_WIDTH = 32
) (
  input  wire  clk,
  input  wire  rst_n,
  kos_in_if.sink    in_ch,
  kos_out_if.source out_ch,
  kos_cfg_if.sink   cfg_ch
);
  import kos_pkg::*;

  localparam int CW = $clog2(K_MAX + 1);
  localparam int IW = (K_MAX > 1) ? $clog2(K_MAX) : 1;

  logic [RANK_W-1:0]             rank_k_r;
  logic                          select_largest_r;
  logic [CW-1:0]                 count_r;
  logic                          pending_r;
  logic                          out_valid_r;
  logic signed [VALUE_WIDTH-1:0] out_value_r;
  logic                          out_too_few_r;

  logic [CW-1:0]                 k_eff;
  logic                          in_fire;
  logic                          append;
  logic                          res_take;
  logic [IW-1:0]                 top_idx;
  kos_cell_ctl_t                 ctl;

  logic signed [VALUE_WIDTH-1:0] cur   [K_MAX];
  logic [K_MAX-1:0]              ins_v;
  logic [K_MAX-1:0]              gt_v;

  always_comb begin
    if (rank_k_r == '0) begin
      k_eff = CW'(1);
    end else if (32'(rank_k_r) > K_MAX) begin
      k_eff = CW'(K_MAX);
    end else begin
      k_eff = CW'(rank_k_r);
    end
  end

  assign in_ch.ready  = !pending_r;
  assign cfg_ch.ready = 1'b1;
  assign in_fire      = in_ch.valid && !pending_r;
  assign append       = count_r < k_eff;
  assign res_take     = pending_r && (!out_valid_r || out_ch.ready);
  assign top_idx      = IW'(count_r - CW'(1));

  // once full, largest mode evicts the minimum (bottom); smallest mode the top
  assign ctl.load       = in_fire;
  assign ctl.shift_down = select_largest_r && !append;

  for (genvar i = 0; i < K_MAX; i++) begin : g_cell
    logic                          live;
    logic                          b_ins;
    logic signed [VALUE_WIDTH-1:0] b_val;
    logic                          a_gt;
    logic signed [VALUE_WIDTH-1:0] a_val;

    assign live = CW'(i) < count_r;

    if (i == 0) begin : g_bot
      assign b_ins = 1'b0;
      assign b_val = '0;
    end else begin : g_mid_b
      assign b_ins = ins_v[i-1];
      assign b_val = cur[i-1];
    end

    if (i == K_MAX - 1) begin : g_top
      assign a_gt  = 1'b0;
      assign a_val = '0;
    end else begin : g_mid_a
      assign a_gt  = gt_v[i+1];
      assign a_val = cur[i+1];
    end

    kos_cell #(
      .VALUE_WIDTH(VALUE_WIDTH)
    ) u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .live      (live),
      .value_in  (in_ch.value),
      .below_ins (b_ins),
      .below_val (b_val),
      .above_gt  (a_gt),
      .above_val (a_val),
      .cur_val   (cur[i]),
      .ins       (ins_v[i]),
      .gt        (gt_v[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rank_k_r         <= RANK_W'(1);
      select_largest_r <= 1'b0;
      count_r          <= '0;
      pending_r        <= 1'b0;
      out_valid_r      <= 1'b0;
    end else begin
      if (cfg_ch.valid) begin
        unique case (cfg_ch.index)
          CFG_RANK_K:         rank_k_r         <= cfg_ch.data;
          CFG_SELECT_LARGEST: select_largest_r <= cfg_ch.data[0];
          default: ;
        endcase
      end

      if (res_take) begin
        count_r <= '0;
      end else if (in_fire && append) begin
        count_r <= count_r + CW'(1);
      end

      if (res_take) begin
        pending_r <= 1'b0;
      end else if (in_fire && in_ch.last) begin
        pending_r <= 1'b1;
      end

      if (res_take) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end

    // worst kept: top of the sorted chain, or bottom in largest mode
    if (res_take) begin
      out_value_r   <= select_largest_r ? cur[0] : cur[top_idx];
      out_too_few_r <= count_r < k_eff;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.kth_value = out_value_r;
  assign out_ch.too_few   = out_too_few_r;

endmodule

`default_nettype wire

FILE: test/tb.sv
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import kos_pkg::*;

  localparam int VW         = 32;
  localparam int KCAP       = 16;
  localparam int RAND_WORDS = 200;   // per pacing phase
  localparam int SETTLE     = 6;     // cycles after the last result before a register write
  localparam int QUIET_MAX  = 4000;  // cycles with no handshake at all

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 2'd3;

  localparam logic signed [VW-1:0] VAL_MIN = {1'b1, {(VW-1){1'b0}}};
  localparam logic signed [VW-1:0] VAL_MAX = {1'b0, {(VW-1){1'b1}}};

  typedef struct {
    logic signed [VW-1:0] kth_value;
    logic                 too_few;
  } kth_result_t;

  typedef enum logic {ROW_WORD, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t              kind;
    logic signed [VW-1:0]   value;
    logic                   last;
    logic [CFG_IDX_W-1:0]   idx;
    logic [CFG_DATA_W-1:0]  data;
    bit                     typed;
    logic signed [VW-1:0]   exp_value;
    logic                   exp_few;
  } plan_row_t;

  logic clk;
  logic rst_n;

  kos_in_if  #(.VALUE_WIDTH(VW)) in_ch ();
  kos_out_if #(.VALUE_WIDTH(VW)) out_ch ();
  kos_cfg_if                     cfg_ch ();

  kth_order_statistic_select #(
    .K_MAX      (KCAP),
    .VALUE_WIDTH(VW)
  ) uut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  // shadow of the selector
  logic signed [VW-1:0] kept_vals [KCAP];
  int                   kept_n      = 0;
  logic [RANK_W-1:0]    cur_rank    = RANK_W'(1);
  logic                 cur_largest = 1'b0;
  kth_result_t          pending_kth [$];

  // hand-typed expectation for the directed word being driven
  bit                   typed_on    = 1'b0;
  logic signed [VW-1:0] typed_value = '0;
  logic                 typed_few   = 1'b0;

  int gap_pct     = 0;
  int stall_pct   = 0;
  int fail_count  = 0;
  int words_in    = 0;
  int results_out = 0;
  int reg_writes  = 0;
  int quiet       = 0;

  plan_row_t plan [$];

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic bit beats(input logic signed [VW-1:0] a, input logic signed [VW-1:0] b);
    return cur_largest ? (a > b) : (a < b);
  endfunction

  // the kept entry that a better value would push out
  function automatic int worst_slot();
    int w;
    w = 0;
    for (int i = 1; i < kept_n; i++)
      if (beats(kept_vals[w], kept_vals[i])) w = i;
    return w;
  endfunction

  task automatic absorb_value(input logic signed [VW-1:0] v, input logic is_last);
    int k_eff;
    int w;
    kth_result_t r;
    k_eff = (cur_rank == 0) ? 1 : (cur_rank > KCAP) ? KCAP : int'(cur_rank);
    if (kept_n < k_eff) begin
      kept_vals[kept_n] = v;
      kept_n++;
    end else if (kept_n > 0) begin
      w = worst_slot();
      if (beats(v, kept_vals[w])) kept_vals[w] = v;
    end
    if (is_last) begin
      w = worst_slot();
      r.kth_value = kept_vals[w];
      r.too_few   = (kept_n < k_eff);
      if (typed_on) begin
        r.kth_value = typed_value;
        r.too_few   = typed_few;
      end
      pending_kth.push_back(r);
      kept_n = 0;
    end
  endtask

  always @(posedge clk) begin : monitor
    kth_result_t want;
    if (rst_n) begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        reg_writes++;
        case (cfg_ch.index)
          CFG_RANK_K:         cur_rank = cfg_ch.data;
          CFG_SELECT_LARGEST: cur_largest = cfg_ch.data[0];
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready) begin
        words_in++;
        absorb_value(in_ch.value, in_ch.last);
      end
      if (out_ch.valid && out_ch.ready) begin
        results_out++;
        if (pending_kth.size() == 0) begin
          $error("result word with nothing pending: kth_value %0d too_few %0b",
                 out_ch.kth_value, out_ch.too_few);
          fail_count++;
        end else begin
          want = pending_kth.pop_front();
          if (out_ch.kth_value !== want.kth_value) begin
            $error("kth_value: expected %0d, got %0d", want.kth_value, out_ch.kth_value);
            fail_count++;
          end
          if (out_ch.too_few !== want.too_few) begin
            $error("too_few: expected %0b, got %0b", want.too_few, out_ch.too_few);
            fail_count++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready))
        quiet <= 0;
      else
        quiet <= quiet + 1;
      if (quiet >= QUIET_MAX) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  function automatic plan_row_t word_row(input logic signed [VW-1:0] v, input logic l);
    plan_row_t r;
    r = '{kind: ROW_WORD, value: v, last: l, idx: '0, data: '0,
          typed: 1'b0, exp_value: '0, exp_few: 1'b0};
    return r;
  endfunction

  function automatic plan_row_t typed_row(input logic signed [VW-1:0] v,
                                          input logic signed [VW-1:0] ev, input logic ef);
    plan_row_t r;
    r = word_row(v, 1'b1);
    r.typed     = 1'b1;
    r.exp_value = ev;
    r.exp_few   = ef;
    return r;
  endfunction

  function automatic plan_row_t cfg_row(input logic [CFG_IDX_W-1:0] i,
                                        input logic [CFG_DATA_W-1:0] d);
    plan_row_t r;
    r = word_row('0, 1'b0);
    r.kind = ROW_CFG;
    r.idx  = i;
    r.data = d;
    return r;
  endfunction

  function automatic logic signed [VW-1:0] pick_value(input int style);
    int t;
    case (style)
      0: return $urandom;
      1: begin
        t = $urandom_range(6);  // narrow band, lots of ties
        return t - 3;
      end
      2: begin
        case ($urandom_range(5))
          0: return VAL_MIN;
          1: return VAL_MIN + 1;
          2: return -1;
          3: return 0;
          4: return VAL_MAX - 1;
          default: return VAL_MAX;
        endcase
      end
      default: begin
        t = $urandom_range(2000);
        return t - 1000;
      end
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_rank();
    case ($urandom_range(9))
      0: return 5'd0;
      1: return 5'd16;
      2: return 5'd17 + 5'($urandom_range(14));  // beyond capacity
      default: return 5'($urandom_range(1, 16));
    endcase
  endfunction

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_word(input logic signed [VW-1:0] v, input logic is_last);
    while ($urandom_range(99) < gap_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.value <= v;
    in_ch.last  <= is_last;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  task automatic drain_and_settle();
    in_ch.valid <= 1'b0;
    while (pending_kth.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] i, input logic [CFG_DATA_W-1:0] d);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= i;
    cfg_ch.data  <= d;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  initial begin : stimulus
    int                 set_len;
    int                 style;
    int                 mid_at;
    int                 sent;
    logic [CFG_IDX_W-1:0] mid_idx;
    int                 gap_by_phase   [4];
    int                 stall_by_phase [4];
    logic [4:0]         rank_by_phase  [4];

    gap_by_phase   = '{0, 68, 0, 33};
    stall_by_phase = '{0, 0, 68, 33};
    rank_by_phase  = '{5'd16, 5'd1, 5'd31, 5'd8};

    rst_n        = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.value  = '0;
    in_ch.last   = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data  = '0;

    plan = '{
      typed_row(5, 5, 1'b0),
      word_row(VAL_MIN, 1'b0), typed_row(VAL_MAX, VAL_MIN, 1'b0),
      cfg_row(CFG_SELECT_LARGEST, 5'd1),
      word_row(VAL_MIN, 1'b0), typed_row(VAL_MAX, VAL_MAX, 1'b0),
      // rank zero acts as rank one
      cfg_row(CFG_RANK_K, 5'd0),
      word_row(7, 1'b0), typed_row(-3, 7, 1'b0),
      // short set: worst kept value, flagged
      cfg_row(CFG_RANK_K, 5'd3), cfg_row(CFG_SELECT_LARGEST, 5'b11110),
      word_row(10, 1'b0), typed_row(-1, 10, 1'b1),
      // ties do not replace; spare index is ignored
      cfg_row(CFG_RANK_K, 5'd2), cfg_row(CFG_IDX_SPARE, 5'h1f),
      word_row(4, 1'b0), word_row(9, 1'b0), word_row(9, 1'b0), word_row(1, 1'b1),
      // rank above capacity saturates
      cfg_row(CFG_RANK_K, 5'd31), cfg_row(CFG_SELECT_LARGEST, 5'd1),
      word_row(0, 1'b0), word_row(-1, 1'b0), typed_row(1, -1, 1'b1),
      // mode flipped in the middle of a set
      cfg_row(CFG_RANK_K, 5'd2), cfg_row(CFG_SELECT_LARGEST, 5'd0),
      word_row(8, 1'b0), word_row(3, 1'b0), cfg_row(CFG_SELECT_LARGEST, 5'd1),
      word_row(5, 1'b1),
      // rank lowered in the middle of a set
      cfg_row(CFG_RANK_K, 5'd3), cfg_row(CFG_SELECT_LARGEST, 5'd0),
      word_row(6, 1'b0), word_row(2, 1'b0), word_row(7, 1'b0), cfg_row(CFG_RANK_K, 5'd1),
      word_row(4, 1'b1)
    };

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (plan[n]) begin
      if (plan[n].kind == ROW_CFG) begin
        drain_and_settle();
        write_reg(plan[n].idx, plan[n].data);
      end else begin
        typed_on    = plan[n].typed;
        typed_value = plan[n].exp_value;
        typed_few   = plan[n].exp_few;
        send_word(plan[n].value, plan[n].last);
        typed_on    = 1'b0;
      end
    end

    for (int p = 0; p < 4; p++) begin
      drain_and_settle();
      gap_pct   = gap_by_phase[p];
      stall_pct = stall_by_phase[p];
      write_reg(CFG_RANK_K, rank_by_phase[p]);
      write_reg(CFG_SELECT_LARGEST, {4'($urandom_range(15)), p[0]});
      sent = 0;
      while (sent < RAND_WORDS) begin
        if ($urandom_range(7) == 0) begin
          drain_and_settle();
          write_reg(CFG_RANK_K, pick_rank());
          write_reg(CFG_SELECT_LARGEST, 5'($urandom_range(31)));
          if ($urandom_range(3) == 0) write_reg(CFG_IDX_SPARE, 5'($urandom_range(31)));
        end
        set_len = ($urandom_range(9) == 0) ? $urandom_range(17, 40) : $urandom_range(1, 20);
        style   = $urandom_range(3);
        mid_at  = (set_len > 2 && $urandom_range(9) == 0) ? $urandom_range(1, set_len - 1) : -1;
        for (int i = 0; i < set_len; i++) begin
          if (i == mid_at) begin
            drain_and_settle();
            mid_idx = $urandom_range(1) ? CFG_RANK_K : CFG_SELECT_LARGEST;
            write_reg(mid_idx, (mid_idx == CFG_RANK_K) ? pick_rank() : 5'($urandom_range(31)));
          end
          send_word(pick_value(style), i == set_len - 1);
          sent++;
        end
      end
    end

    in_ch.valid <= 1'b0;
    while (pending_kth.size() != 0) @(negedge clk);
    repeat (SETTLE * 2) @(negedge clk);

    $display("covered %0d words in %0d sets with %0d register writes,", words_in, results_out,
             reg_writes);
    $display("ranks 0..31 in both modes, paced free, sender-idle, receiver-stall and both");
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

`default_nettype wire
